FILE: design/upd_pkg.sv
package upd_pkg;

  // parse phases
  localparam logic [1:0] PH_PATH = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_ROOTED = 3'd1;
  localparam logic [2:0] ST_BAD_ESCAPE = 3'd2;
  localparam logic [2:0] ST_FORBIDDEN  = 3'd3;
  localparam logic [2:0] ST_DOT_DOT    = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUEST   = 8'h3f;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // length of the "index.html" extension
  localparam int unsigned IDX_LEN = 10;
  localparam int unsigned IDX_W   = $clog2(IDX_LEN + 1);

  // one character of "index.html"
  function automatic logic [7:0] idx_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h69; // i
      4'd1:    c = 8'h6e; // n
      4'd2:    c = 8'h64; // d
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h78; // x
      4'd5:    c = 8'h2e; // .
      4'd6:    c = 8'h68; // h
      4'd7:    c = 8'h74; // t
      4'd8:    c = 8'h6d; // m
      4'd9:    c = 8'h6c; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // hex digit decode: bit 4 is set when the byte is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // keep the smallest nonzero status
  function automatic logic [2:0] err_latch(input logic [2:0] cur, input logic [2:0] code);
    logic [2:0] r;
    r = cur;
    if (cur == ST_OK || code < cur) begin
      r = code;
    end
    return r;
  endfunction

endpackage

FILE: design/url_path_percent_decoder_unit.sv
// URL path percent decoder.
// Input stream: one raw byte of a request target per transfer on in_tdata,
// in_tlast on the final byte. Result stream: out_tuser = 1 marks a decoded
// path byte in out_tdata[7:0]; out_tlast = 1 marks the closing status item
// with the status in out_tdata[10:8] (0 ok, 1 not rooted, 2 bad escape,
// 3 forbidden byte, 4 dot-dot segment). Everything from the first '?' is
// dropped, %XX escapes are decoded, and a path that is just "/" is followed
// by "index.html" when the status is ok. Bytes are sent as they form;
// discard them when the status is nonzero.
// A decoded byte is registered, so it appears in the cycle after its input transfer.
// Throughput: one input byte per cycle while the output is taken. After a
// last byte, input is held off while the tail (up to ten extension bytes
// and the status item) goes out, one result per cycle while it is taken.
// Reset clears the decoder to the start of a new target with no output
// pending. When the receiver stalls, the output register holds its item and
// in_tready drops, so nothing is lost.
module url_path_percent_decoder_unit
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [10:8] status, rest zero
  output logic        out_tuser,  // [0] char_valid
  output logic        out_tlast
);

  // decoder state
  logic [1:0] phase_r, phase_nxt;
  logic       at_start_r, at_start_nxt;
  logic [3:0] hi_nib_r, hi_nib_nxt;
  logic [1:0] seg_len_r, seg_len_nxt;
  logic       seg_dots_r, seg_dots_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [2:0] err_r, err_nxt;

  // tail sequencer
  logic             tail_busy_r, tail_busy_nxt;
  logic             tail_idx_r, tail_idx_nxt;
  logic [IDX_W-1:0] tail_cnt_r, tail_cnt_nxt;
  logic [2:0]       tail_st_r, tail_st_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_cv_r, out_cv_nxt;
  logic       out_done_r, out_done_nxt;
  logic [2:0] out_st_r, out_st_nxt;

  logic out_free;
  logic in_acc;
  logic emit;
  logic [7:0] emit_b;
  logic [4:0] hx;
  logic [2:0] fin_err;
  logic       fin_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !tail_busy_r && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign hx        = hex_val(in_tdata);

  // per-byte decode
  always_comb begin
    phase_nxt    = phase_r;
    at_start_nxt = at_start_r;
    hi_nib_nxt   = hi_nib_r;
    seg_len_nxt  = seg_len_r;
    seg_dots_nxt = seg_dots_r;
    dcnt_nxt     = dcnt_r;
    err_nxt      = err_r;
    emit         = 1'b0;
    emit_b       = in_tdata;
    fin_err      = ST_OK;
    fin_idx      = 1'b0;

    // phase step
    if (at_start_r) begin
      at_start_nxt = 1'b0;
      if (in_tdata == CH_SLASH) begin
        emit = 1'b1;
      end else begin
        err_nxt   = err_latch(err_nxt, ST_NOT_ROOTED);
        phase_nxt = PH_SKIP;
      end
    end else begin
      case (phase_r)
        PH_PATH: begin
          if (in_tdata == CH_QUEST) begin
            phase_nxt = PH_SKIP;
          end else if (in_tdata == CH_PERCENT) begin
            phase_nxt = PH_HIGH;
          end else begin
            emit = 1'b1;
          end
        end
        PH_HIGH: begin
          if (!hx[4]) begin
            err_nxt   = err_latch(err_nxt, ST_BAD_ESCAPE);
            phase_nxt = PH_SKIP;
          end else begin
            hi_nib_nxt = hx[3:0];
            phase_nxt  = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!hx[4]) begin
            err_nxt   = err_latch(err_nxt, ST_BAD_ESCAPE);
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_PATH;
            emit      = 1'b1;
            emit_b    = {hi_nib_r, hx[3:0]};
          end
        end
        default: begin
        end
      endcase
    end

    // segment and count tracking for a decoded byte
    if (emit) begin
      if (emit_b == CH_BSLASH || emit_b == CH_NUL) begin
        err_nxt = err_latch(err_nxt, ST_FORBIDDEN);
      end
      if (emit_b == CH_SLASH) begin
        if (dcnt_r != 2'd0 && seg_len_r == 2'd2 && seg_dots_r) begin
          err_nxt = err_latch(err_nxt, ST_DOT_DOT);
        end
        seg_len_nxt  = 2'd0;
        seg_dots_nxt = 1'b1;
      end else begin
        if (seg_len_r != 2'd3) begin
          seg_len_nxt = seg_len_r + 2'd1;
        end
        if (emit_b != CH_DOT) begin
          seg_dots_nxt = 1'b0;
        end
      end
      if (dcnt_r != 2'd3) begin
        dcnt_nxt = dcnt_r + 2'd1;
      end
    end

    // end of target checks, then back to the start state
    if (in_tlast) begin
      fin_err = err_nxt;
      if (phase_nxt == PH_HIGH || phase_nxt == PH_LOW) begin
        fin_err = err_latch(fin_err, ST_BAD_ESCAPE);
      end
      if (dcnt_nxt != 2'd0 && seg_len_nxt == 2'd2 && seg_dots_nxt) begin
        fin_err = err_latch(fin_err, ST_DOT_DOT);
      end
      fin_idx      = (fin_err == ST_OK) && (dcnt_nxt == 2'd1);
      phase_nxt    = PH_PATH;
      at_start_nxt = 1'b1;
      hi_nib_nxt   = 4'd0;
      seg_len_nxt  = 2'd0;
      seg_dots_nxt = 1'b1;
      dcnt_nxt     = 2'd0;
      err_nxt      = ST_OK;
    end
  end

  // output register and tail sequencing
  always_comb begin
    tail_busy_nxt = tail_busy_r;
    tail_idx_nxt  = tail_idx_r;
    tail_cnt_nxt  = tail_cnt_r;
    tail_st_nxt   = tail_st_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_done_nxt  = out_done_r;
    out_st_nxt    = out_st_r;

    if (tail_busy_r && out_free) begin
      out_valid_nxt = 1'b1;
      if (tail_idx_r && tail_cnt_r < IDX_W'(IDX_LEN)) begin
        out_char_nxt = idx_char(tail_cnt_r);
        out_cv_nxt   = 1'b1;
        out_done_nxt = 1'b0;
        out_st_nxt   = ST_OK;
        tail_cnt_nxt = tail_cnt_r + IDX_W'(1);
      end else begin
        out_char_nxt  = 8'd0;
        out_cv_nxt    = 1'b0;
        out_done_nxt  = 1'b1;
        out_st_nxt    = tail_st_r;
        tail_busy_nxt = 1'b0;
      end
    end else if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_b;
      out_cv_nxt    = 1'b1;
      out_done_nxt  = 1'b0;
      out_st_nxt    = ST_OK;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    // a last byte arms the tail
    if (in_acc && in_tlast) begin
      tail_busy_nxt = 1'b1;
      tail_idx_nxt  = fin_idx;
      tail_cnt_nxt  = '0;
      tail_st_nxt   = fin_err;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PATH;
      at_start_r  <= 1'b1;
      hi_nib_r    <= 4'd0;
      seg_len_r   <= 2'd0;
      seg_dots_r  <= 1'b1;
      dcnt_r      <= 2'd0;
      err_r       <= ST_OK;
      tail_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r    <= phase_nxt;
        at_start_r <= at_start_nxt;
        hi_nib_r   <= hi_nib_nxt;
        seg_len_r  <= seg_len_nxt;
        seg_dots_r <= seg_dots_nxt;
        dcnt_r     <= dcnt_nxt;
        err_r      <= err_nxt;
      end
      tail_busy_r <= tail_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tail_idx_r <= tail_idx_nxt;
    tail_cnt_r <= tail_cnt_nxt;
    tail_st_r  <= tail_st_nxt;
    out_char_r <= out_char_nxt;
    out_cv_r   <= out_cv_nxt;
    out_done_r <= out_done_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_st_r, out_char_r};
  assign out_tuser  = out_cv_r;
  assign out_tlast  = out_done_r;

  // no input is taken while the tail is going out
  a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    tail_busy_r |-> !in_tready)
    else $error("input accepted during tail");

  // a status item carries no byte and a byte item carries no status
  a_item_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cv_r != out_done_r) && (out_cv_r || out_char_r == 8'd0)
      && (out_done_r || out_st_r == ST_OK))
    else $error("malformed result item");

  // extension bytes only follow an ok status
  a_idx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    tail_busy_r && tail_idx_r |-> tail_st_r == ST_OK)
    else $error("extension armed with error status");

  // while the status item is being taken, the tail is idle
  a_done_ends_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r && out_tready |-> !tail_busy_r)
    else $error("tail still busy after status");

endmodule
